// ===== hdl/vrra_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrra_pkg
// types and constants shared by the ring allocator modules
// ----------------------------------------------------------------------------
package vrra_pkg;

    localparam int LINE_CAPACITY_DEF = 1024;
    localparam int ARENA_BYTES_DEF   = 16777216;
    localparam int SEGMENT_BYTES_DEF = 8;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_GET    = 3'd1;
    localparam logic [2:0] CMD_SET    = 3'd2;
    localparam logic [2:0] CMD_TRIM   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  segment_count;
        logic [15:0] text_length;
        logic [15:0] row_count;
        logic [7:0]  line_flags;
        logic [9:0]  line_index;
    } cmd_item_t;

    typedef struct packed {
        logic [25:0] evicted_rows;
        logic [23:0] record_offset;
        logic        hit;
        logic [15:0] out_length;
        logic [15:0] out_rows;
        logic [7:0]  out_segments;
        logic [7:0]  out_flags;
        logic [10:0] line_count;
        logic [31:0] evicted_total;
    } result_item_t;

    // classified item handed from front to back
    typedef struct packed {
        cmd_item_t   item;
        logic [24:0] rec_bytes;
    } work_item_t;

endpackage

// ===== hdl/variable_record_ring_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_record_ring_allocator
// circular arena allocator for variable-length records with a descriptor ring
// ----------------------------------------------------------------------------
// Each command yields one result strobe. The back end steps a command through
// idle, read, evaluate and done states, and an append adds a write state; each
// evicted line repeats the evaluate state, since each eviction reads the next
// head descriptor from the metadata memory before the next check. Two commands
// may queue ahead of the back end; busy rises when the queue is full. Results
// cannot be held off, so the receiver never stalls the block.
module variable_record_ring_allocator #(
    parameter int LINE_CAPACITY = vrra_pkg::LINE_CAPACITY_DEF,
    parameter int ARENA_BYTES   = vrra_pkg::ARENA_BYTES_DEF,
    parameter int SEGMENT_BYTES = vrra_pkg::SEGMENT_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  vrra_pkg::cmd_item_t    cmd_item,
    input  logic                   cfg_we,
    input  logic [10:0]            cfg_data,
    output logic                   result_strobe,
    output vrra_pkg::result_item_t result
);
    import vrra_pkg::*;

    logic       q_valid, q_pop;
    work_item_t q_item;

    vrra_front #(
        .SEGMENT_BYTES(SEGMENT_BYTES),
        .DEPTH(2)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .in_item(cmd_item),
        .busy(busy),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_pop(q_pop)
    );

    vrra_back #(
        .LINE_CAPACITY(LINE_CAPACITY),
        .ARENA_BYTES(ARENA_BYTES)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .q_valid(q_valid),
        .q_item(q_item),
        .q_pop(q_pop),
        .result_valid(result_strobe),
        .result(result)
    );

endmodule

// ===== hdl/vrra_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrra_front
// accepts commands, sizes records and queues items for the back end
// ----------------------------------------------------------------------------
module vrra_front #(
    parameter int SEGMENT_BYTES = 8,
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  vrra_pkg::cmd_item_t   in_item,
    output logic                  busy,
    output logic                  q_valid,
    output vrra_pkg::work_item_t  q_item,
    input  logic                  q_pop
);
    import vrra_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    work_item_t        mem_reg [DEPTH];
    logic [PW-1:0]     wp_reg, rp_reg;
    logic [PW:0]       cnt_reg;
    work_item_t        w;
    logic              push;
    logic [24:0]       sz;

    assign busy    = (cnt_reg == (PW+1)'(DEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_item  = mem_reg[rp_reg];

    always_comb
    begin
        sz = 25'(in_item.segment_count) * 25'(SEGMENT_BYTES)
           + 25'(in_item.text_length) + 25'd3;
        w.item = in_item;
        w.rec_bytes = sz & ~25'd3;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop);
        end
    end

endmodule

// ===== hdl/vrra_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrra_back
// executes commands against the descriptor ring and arena pointers
// ----------------------------------------------------------------------------
module vrra_back #(
    parameter int LINE_CAPACITY = 1024,
    parameter int ARENA_BYTES = 16777216
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [10:0]            cfg_data,
    input  logic                   q_valid,
    input  vrra_pkg::work_item_t   q_item,
    output logic                   q_pop,
    output logic                   result_valid,
    output vrra_pkg::result_item_t result
);
    import vrra_pkg::*;

    localparam int SW = $clog2(LINE_CAPACITY);
    localparam int CW = SW + 1;
    localparam logic [SW:0] CAP_W = (SW+1)'(LINE_CAPACITY);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_EVAL  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    logic [23:0] off_mem [LINE_CAPACITY];
    logic [47:0] info_mem [LINE_CAPACITY];

    state_t      state_reg, state_next;
    logic [SW-1:0] head_reg, head_next;
    logic [CW-1:0] held_reg, held_next;
    logic [24:0] wofs_reg, wofs_next;
    logic [31:0] etot_reg, etot_next;
    logic [CW-1:0] maxl_reg;
    work_item_t  cur_reg, cur_next;
    logic [25:0] erows_reg, erows_next;
    logic [24:0] start_reg, start_next;
    logic [23:0] rd_off_reg;
    logic [47:0] rd_info_reg;
    logic [SW-1:0] rd_addr;
    logic        wr_en;
    logic [SW-1:0] wr_addr;
    logic [23:0] wr_off;
    logic [47:0] wr_info;
    logic        wr_off_en;
    logic [SW:0] idx_sum;
    logic [SW:0] tail_sum;
    logic [SW:0] head_sum;
    logic [SW-1:0] idx_slot;
    logic [SW-1:0] tail_slot;
    logic [SW-1:0] head_inc;
    logic        idx_in;
    logic        evict;
    logic        dropped_reg, dropped_next;
    logic        hit_reg, hit_next;
    logic [25:0] rec_end;
    logic [16:0] cfg_v;

    // slot arithmetic wraps at the ring capacity
    assign idx_sum   = {1'b0, head_reg} + (SW+1)'(cur_reg.item.line_index);
    assign idx_slot  = (idx_sum >= CAP_W) ? SW'(idx_sum - CAP_W) : idx_sum[SW-1:0];
    assign tail_sum  = {1'b0, head_reg} + held_reg;
    assign tail_slot = (tail_sum >= CAP_W) ? SW'(tail_sum - CAP_W) : tail_sum[SW-1:0];
    assign head_sum  = {1'b0, head_reg} + (SW+1)'(1);
    assign head_inc  = (head_sum >= CAP_W) ? '0 : head_sum[SW-1:0];
    assign idx_in    = (17'(cur_reg.item.line_index) < 17'(held_reg));
    assign rec_end   = 26'(wofs_reg) + 26'(cur_reg.rec_bytes);

    always_ff @(posedge clk)
    begin
        rd_off_reg  <= off_mem[rd_addr];
        rd_info_reg <= info_mem[rd_addr];
        if (wr_en)
        begin
            info_mem[wr_addr] <= wr_info;
        end
        if (wr_off_en)
        begin
            off_mem[wr_addr] <= wr_off;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        held_next  = held_reg;
        wofs_next  = wofs_reg;
        etot_next  = etot_reg;
        cur_next   = cur_reg;
        erows_next = erows_reg;
        start_next = start_reg;
        dropped_next = dropped_reg;
        hit_next   = hit_reg;
        rd_addr    = head_reg;
        wr_en      = 1'b0;
        wr_off_en  = 1'b0;
        wr_addr    = tail_slot;
        wr_off     = start_reg[23:0];
        wr_info    = {cur_reg.item.line_flags, cur_reg.item.segment_count,
                      cur_reg.item.row_count, cur_reg.item.text_length};
        q_pop      = 1'b0;
        evict      = 1'b0;
        result_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    erows_next = '0;
                    start_next = '0;
                    dropped_next = 1'b0;
                    hit_next   = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                // address the head (append/trim) or the indexed slot (get/set)
                if (cur_reg.item.cmd == CMD_GET || cur_reg.item.cmd == CMD_SET)
                begin
                    rd_addr = idx_slot;
                end
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                case (cur_reg.item.cmd)
                    CMD_APPEND:
                    begin
                        if (held_reg == '0)
                        begin
                            wofs_next  = '0;
                            start_next = '0;
                            dropped_next = (26'(cur_reg.rec_bytes) > 26'(ARENA_BYTES));
                            state_next = S_WRITE;
                        end
                        else if (held_reg >= maxl_reg)
                        begin
                            evict = 1'b1;
                        end
                        else if (25'(rd_off_reg) <= wofs_reg)
                        begin
                            if (rec_end <= 26'(ARENA_BYTES))
                            begin
                                start_next = wofs_reg;
                                state_next = S_WRITE;
                            end
                            else if (cur_reg.rec_bytes < 25'(rd_off_reg))
                            begin
                                start_next = '0;
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                evict = 1'b1;
                            end
                        end
                        else if (rec_end < 26'(rd_off_reg))
                        begin
                            start_next = wofs_reg;
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            evict = 1'b1;
                        end
                    end
                    CMD_GET:
                    begin
                        // keep the indexed descriptor in the read registers
                        rd_addr    = idx_slot;
                        hit_next   = idx_in;
                        state_next = S_DONE;
                    end
                    CMD_SET:
                    begin
                        if (idx_in)
                        begin
                            hit_next = 1'b1;
                            wr_en    = 1'b1;
                            wr_addr  = idx_slot;
                            wr_info  = {rd_info_reg[47:32], cur_reg.item.row_count,
                                        rd_info_reg[15:0]};
                        end
                        state_next = S_DONE;
                    end
                    CMD_TRIM:
                    begin
                        if (held_reg > maxl_reg)
                        begin
                            evict = 1'b1;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        head_next  = '0;
                        held_next  = '0;
                        wofs_next  = '0;
                        etot_next  = '0;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
                if (evict)
                begin
                    erows_next = erows_reg + 26'(rd_info_reg[31:16]);
                    head_next  = head_inc;
                    held_next  = held_reg - 1'b1;
                    etot_next  = etot_reg + 1'b1;
                    if (held_reg == CW'(1))
                    begin
                        wofs_next = '0;
                    end
                    rd_addr    = head_inc;
                end
            end
            S_WRITE:
            begin
                if (dropped_reg)
                begin
                    erows_next = erows_reg + 26'(cur_reg.item.row_count);
                    start_next = '0;
                end
                else
                begin
                    wr_en     = 1'b1;
                    wr_off_en = 1'b1;
                    held_next = held_reg + 1'b1;
                    wofs_next = start_reg + cur_reg.rec_bytes;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                result_valid = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result = '0;
        result.evicted_rows  = erows_reg;
        result.line_count    = 11'(held_reg);
        result.evicted_total = etot_reg;
        result.hit           = hit_reg;
        if (cur_reg.item.cmd == CMD_APPEND)
        begin
            result.record_offset = start_reg[23:0];
        end
        else if (cur_reg.item.cmd == CMD_GET && hit_reg)
        begin
            result.record_offset = rd_off_reg;
            result.out_length    = rd_info_reg[15:0];
            result.out_rows      = rd_info_reg[31:16];
            result.out_segments  = rd_info_reg[39:32];
            result.out_flags     = rd_info_reg[47:40];
        end
    end

    assign cfg_v = (cfg_data == '0) ? 17'd1 :
                   (17'(cfg_data) > 17'(LINE_CAPACITY)) ? 17'(LINE_CAPACITY) :
                   17'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            held_reg  <= '0;
            wofs_reg  <= '0;
            etot_reg  <= '0;
            maxl_reg  <= (LINE_CAPACITY < 1024) ? CW'(LINE_CAPACITY) : CW'(1024);
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            held_reg  <= held_next;
            wofs_reg  <= wofs_next;
            etot_reg  <= etot_next;
            if (cfg_we)
            begin
                maxl_reg <= CW'(cfg_v);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        erows_reg   <= erows_next;
        start_reg   <= start_next;
        dropped_reg <= dropped_next;
        hit_reg     <= hit_next;
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the ring allocator against a built-in predictor: directed corner
// items, then random command streams with sender gaps and max_lines changes
// ----------------------------------------------------------------------------
module tb;
    import vrra_pkg::*;

    localparam int CAP   = 1024;
    localparam int ARENA = 16777216;
    localparam int SEGB  = 8;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    cmd_item_t    cmd_item;
    logic         cfg_we;
    logic [10:0]  cfg_data;
    logic         result_strobe;
    result_item_t result;

    variable_record_ring_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd_item(cmd_item), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .result_strobe(result_strobe), .result(result)
    );

    // predictor state
    logic [23:0]  line_off [CAP];
    logic [15:0]  line_len [CAP];
    logic [15:0]  line_rows [CAP];
    logic [7:0]   line_segs [CAP];
    logic [7:0]   line_flg [CAP];
    int unsigned  head_slot;
    int unsigned  lines_held;
    longint unsigned write_off;
    logic [31:0]  evict_count;
    int unsigned  line_limit;

    cmd_item_t    pending_items [$];
    result_item_t expected_results [$];
    int           idle_pct;
    int           mismatches;
    logic         busy_at_edge;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned drop_oldest();
        int unsigned r;
        r = line_rows[head_slot];
        head_slot = (head_slot + 1) % CAP;
        lines_held--;
        evict_count++;
        if (lines_held == 0)
            write_off = 0;
        return r;
    endfunction

    function automatic result_item_t predict_result(cmd_item_t c);
        result_item_t    r;
        longint unsigned rec;
        longint unsigned place;
        longint unsigned oldest;
        int unsigned     evicted;
        int unsigned     s;
        r = '0;
        evicted = 0;
        place = 0;
        if (c.cmd == CMD_APPEND)
        begin
            rec = (longint'(c.segment_count) * SEGB + c.text_length + 3) & ~64'd3;
            forever
            begin
                if (lines_held == 0)
                begin
                    write_off = 0;
                    break;
                end
                if (lines_held >= line_limit)
                begin
                    evicted += drop_oldest();
                    continue;
                end
                oldest = line_off[head_slot];
                if (oldest <= write_off)
                begin
                    if (write_off + rec <= ARENA)
                    begin
                        place = write_off;
                        break;
                    end
                    if (rec < oldest)
                    begin
                        place = 0;
                        break;
                    end
                end
                else if (write_off + rec < oldest)
                begin
                    place = write_off;
                    break;
                end
                evicted += drop_oldest();
            end
            if (place + rec > ARENA)
                evicted += c.row_count;
            else
            begin
                s = (head_slot + lines_held) % CAP;
                line_off[s] = place[23:0];
                line_len[s] = c.text_length;
                line_rows[s] = c.row_count;
                line_segs[s] = c.segment_count;
                line_flg[s] = c.line_flags;
                lines_held++;
                write_off = place + rec;
                r.record_offset = place[23:0];
            end
        end
        else if (c.cmd == CMD_GET)
        begin
            if (c.line_index < lines_held)
            begin
                s = (head_slot + c.line_index) % CAP;
                r.hit = 1'b1;
                r.record_offset = line_off[s];
                r.out_length = line_len[s];
                r.out_rows = line_rows[s];
                r.out_segments = line_segs[s];
                r.out_flags = line_flg[s];
            end
        end
        else if (c.cmd == CMD_SET)
        begin
            if (c.line_index < lines_held)
            begin
                r.hit = 1'b1;
                line_rows[(head_slot + c.line_index) % CAP] = c.row_count;
            end
        end
        else if (c.cmd == CMD_TRIM)
        begin
            while (lines_held > line_limit)
                evicted += drop_oldest();
        end
        else if (c.cmd == CMD_CLEAR)
        begin
            head_slot = 0;
            lines_held = 0;
            write_off = 0;
            evict_count = 0;
        end
        r.evicted_rows = evicted[25:0];
        r.line_count = lines_held[10:0];
        r.evicted_total = evict_count;
        return r;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (start && !busy_at_edge)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                cmd_item <= pending_items.pop_front();
            else
                start <= 1'b0;
        end
        else if (!start && pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            cmd_item <= pending_items.pop_front();
            start <= 1'b1;
        end
    end

    // acceptance as seen at the last rising edge
    always @(posedge clk)
    begin
        busy_at_edge <= busy;
        if (rst_n && start && !busy)
            expected_results.push_back(predict_result(cmd_item));
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else if (result !== expected_results[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", expected_results[0], result);
                void'(expected_results.pop_front());
            end
            else
                void'(expected_results.pop_front());
        end
    end

    function automatic cmd_item_t make_item(logic [2:0] op, int segs, int len, int rows,
                                            int flg, int idx);
        cmd_item_t c;
        c.cmd = op;
        c.segment_count = segs[7:0];
        c.text_length = len[15:0];
        c.row_count = rows[15:0];
        c.line_flags = flg[7:0];
        c.line_index = idx[9:0];
        return c;
    endfunction

    function automatic cmd_item_t random_item();
        int k;
        int len;
        k = $urandom_range(99);
        len = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(300);
        if (k < 55)
            return make_item(CMD_APPEND, $urandom_range(255), len, $urandom_range(65535),
                             $urandom_range(255), 0);
        else if (k < 75)
            return make_item(CMD_GET, 0, 0, 0, 0,
                             ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                      : $urandom_range(lines_held + 4));
        else if (k < 88)
            return make_item(CMD_SET, 0, 0, $urandom_range(65535), 0,
                             ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                      : $urandom_range(lines_held + 4));
        else if (k < 94)
            return make_item(CMD_TRIM, $urandom_range(255), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(255),
                             $urandom_range(1023));
        else if (k < 97)
            return make_item(CMD_CLEAR, 0, 0, 0, 0, 0);
        else
            return make_item(3'($urandom_range(7, 5)), $urandom_range(255),
                             $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(255), $urandom_range(1023));
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || start || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value[10:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (value[10:0] < 1)
            line_limit = 1;
        else if (value[10:0] > CAP)
            line_limit = CAP;
        else
            line_limit = value[10:0];
    endtask

    initial
    begin
        int limits [6] = '{1, 2, 1024, 0, 2047, 37};
        int phase_idle [4] = '{0, 74, 0, 26};
        rst_n = 1'b0;
        start = 1'b0;
        cmd_item = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        idle_pct = 0;
        mismatches = 0;
        head_slot = 0;
        lines_held = 0;
        write_off = 0;
        evict_count = 0;
        line_limit = CAP;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        pending_items.push_back(make_item(CMD_GET, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_APPEND, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_APPEND, 255, 65535, 65535, 255, 1023));
        pending_items.push_back(make_item(CMD_APPEND, 1, 1, 7, 8'h5a, 0));
        pending_items.push_back(make_item(CMD_GET, 0, 0, 0, 0, 1));
        pending_items.push_back(make_item(CMD_GET, 0, 0, 0, 0, 2));
        pending_items.push_back(make_item(CMD_GET, 0, 0, 0, 0, 3));
        pending_items.push_back(make_item(CMD_GET, 0, 0, 0, 0, 1023));
        pending_items.push_back(make_item(CMD_SET, 0, 0, 16'ha5a5, 0, 2));
        pending_items.push_back(make_item(CMD_SET, 0, 0, 1, 0, 1023));
        pending_items.push_back(make_item(CMD_GET, 0, 0, 0, 0, 2));
        pending_items.push_back(make_item(CMD_TRIM, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_CLEAR, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(3'd5, 255, 65535, 65535, 255, 1023));
        pending_items.push_back(make_item(3'd7, 0, 0, 0, 0, 0));
        wait_drained();

        // small limit, then trim down
        write_limit(3);
        for (int i = 0; i < 6; i++)
            pending_items.push_back(make_item(CMD_APPEND, i, 100, i + 1, i, 0));
        wait_drained();
        write_limit(1024);
        for (int i = 0; i < 4; i++)
            pending_items.push_back(make_item(CMD_APPEND, 0, 4, 9, 0, 0));
        wait_drained();
        write_limit(2);
        pending_items.push_back(make_item(CMD_TRIM, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(CMD_GET, 0, 0, 0, 0, 0));
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_limit(limits[p]);
            idle_pct = phase_idle[p % 4];
            for (int i = 0; i < 150; i++)
            begin
                while (pending_items.size() > 8)
                    @(posedge clk);
                pending_items.push_back(random_item());
                // big records to exercise arena wrap
                if (p == 2 && i == 49)
                    for (int j = 0; j < 300; j++)
                        pending_items.push_back(make_item(CMD_APPEND, 255, 65535,
                                                $urandom_range(65535),
                                                $urandom_range(255), 0));
                if (i == 100)
                    wait_drained();
            end
            wait_drained();
        end
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("variable_record_ring_allocator test passed");
        else
            $display("variable_record_ring_allocator test failed");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("variable_record_ring_allocator test failed");
        $finish;
    end

endmodule
